// ----- rtl/jacm_pkg.sv -----
package jacm_pkg;

    localparam int SAMPLE_W  = 10;
    localparam int EXTENT_W  = 16;
    localparam int REPORT_W  = 8;
    localparam int CFG_IDX_W = 4;
    localparam int HOLD_W    = 10;
    localparam int DIV_W     = 32;
    localparam int CNT_W     = $clog2(DIV_W);

    localparam int DEF_LOGICAL_MIN = 0;
    localparam int DEF_LOGICAL_MAX = 255;
    localparam int DEF_HOLD_TICKS  = 800;

    // samples this close to either rail are ignored
    localparam logic [SAMPLE_W-1:0] RAIL_LOW  = SAMPLE_W'(10);
    localparam logic [SAMPLE_W-1:0] RAIL_HIGH = SAMPLE_W'((1 << SAMPLE_W) - 11);

    localparam logic [EXTENT_W-1:0] CLEARED_LOW  = 16'hFFFE;
    localparam logic [EXTENT_W-1:0] CLEARED_HIGH = 16'h0001;

    localparam logic [EXTENT_W-1:0] RST_DEAD_MAX = 16'd524;
    localparam logic [EXTENT_W-1:0] RST_DEAD_MIN = 16'd500;
    localparam logic [EXTENT_W-1:0] RST_SPAN_MAX = 16'd1012;
    localparam logic [EXTENT_W-1:0] RST_SPAN_MIN = 16'd11;
    localparam logic [EXTENT_W-1:0] RST_ZERO     = 16'd512;

    // floor(2^16 / 5), used for the 15 percent deadzone widening
    localparam logic [13:0] RECIP_5 = 14'd13107;

    // register index within one axis
    localparam logic [1:0] REG_DEAD_MAX = 2'd0;
    localparam logic [1:0] REG_DEAD_MIN = 2'd1;
    localparam logic [1:0] REG_SPAN_MAX = 2'd2;
    localparam logic [1:0] REG_SPAN_MIN = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_DIV,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic start;
        logic mul;
        logic add;
        logic div;
        logic commit;
        logic learn;
        logic learn_dead;
        logic clear;
    } lane_ctl_t;

    typedef struct packed {
        logic                in_dead;
        logic                in_rail;
        logic [REPORT_W-1:0] mapped;
    } lane_res_t;

    function automatic logic [31:0] logical_mid(input int lmin, input int lmax);
        logic [32:0] sum;
        sum = 33'(lmin) + 33'(lmax);
        return sum[32:1];
    endfunction

endpackage

// ----- rtl/jacm_in_if.sv -----
interface jacm_in_if import jacm_pkg::*;;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_axis_a;
    logic [SAMPLE_W-1:0] sample_axis_b;
    logic                button_one;
    logic                button_two;

    modport source (
        output valid, sample_axis_a, sample_axis_b, button_one, button_two,
        input  ready
    );
    modport sink (
        input  valid, sample_axis_a, sample_axis_b, button_one, button_two,
        output ready
    );
endinterface

// ----- rtl/jacm_out_if.sv -----
interface jacm_out_if import jacm_pkg::*;;
    logic                valid;
    logic                ready;
    logic [REPORT_W-1:0] report_axis_a;
    logic [REPORT_W-1:0] report_axis_b;
    logic [1:0]          button_bits;
    logic                calibrating;
    logic                save_pulse;

    modport source (
        output valid, report_axis_a, report_axis_b, button_bits, calibrating, save_pulse,
        input  ready
    );
    modport sink (
        input  valid, report_axis_a, report_axis_b, button_bits, calibrating, save_pulse,
        output ready
    );
endinterface

// ----- rtl/jacm_lane.sv -----
module jacm_lane import jacm_pkg::*;
#(
    parameter int LOGICAL_MIN = DEF_LOGICAL_MIN,
    parameter int LOGICAL_MAX = DEF_LOGICAL_MAX
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lane_ctl_t            ctl,
    input  logic [SAMPLE_W-1:0]  sample,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_sel,
    input  logic [EXTENT_W-1:0]  cfg_data,
    output lane_res_t            res
);

    localparam logic [31:0]         MID_W    = logical_mid(LOGICAL_MIN, LOGICAL_MAX);
    localparam logic [31:0]         LO_RANGE = MID_W - 32'(LOGICAL_MIN);
    localparam logic [31:0]         HI_RANGE = 32'(LOGICAL_MAX) - MID_W;
    localparam logic [REPORT_W-1:0] MID_B    = MID_W[REPORT_W-1:0];
    localparam logic [REPORT_W-1:0] MIN_B    = REPORT_W'(LOGICAL_MIN);
    localparam logic [REPORT_W-1:0] MAX_B    = REPORT_W'(LOGICAL_MAX);

    // axis state
    logic [EXTENT_W-1:0] span_low_reg, span_low_next;
    logic [EXTENT_W-1:0] span_high_reg, span_high_next;
    logic [EXTENT_W-1:0] dead_low_reg, dead_low_next;
    logic [EXTENT_W-1:0] dead_high_reg, dead_high_next;
    logic [EXTENT_W-1:0] zero_reg, zero_next;

    // per-item work registers
    logic [SAMPLE_W-1:0] sample_reg;
    logic                lower_reg;
    logic                sat_lo_reg;
    logic                sat_hi_reg;
    logic [EXTENT_W-1:0] dvsr_reg;
    logic [DIV_W-1:0]    prod_reg;
    logic [DIV_W-1:0]    num_reg;
    logic [EXTENT_W-1:0] rem_reg;
    logic [EXTENT_W-1:0] y_reg;
    logic                neg_reg;
    logic [29:0]         tprod_reg;
    logic                in_dead_reg;

    logic [EXTENT_W-1:0] s16;
    logic                lower;
    logic [EXTENT_W-1:0] lo;
    logic [EXTENT_W-1:0] hi;
    logic [EXTENT_W-1:0] diff;
    logic [31:0]         tgt_span;
    logic [16:0]         width17;
    logic [16:0]         mag17;
    logic [17:0]         mag3;
    logic [EXTENT_W-1:0] y;
    logic [13:0]         q_est;
    logic [EXTENT_W-1:0] rmd;
    logic [14:0]         tol_mag;
    logic signed [18:0]  tol_s;
    logic signed [18:0]  lo_bound;
    logic signed [18:0]  hi_bound;
    logic signed [18:0]  sv;
    logic [16:0]         trial;
    logic                qbit;
    logic                rail;
    logic [16:0]         dead_sum;

    assign s16       = EXTENT_W'(sample_reg);
    assign lower     = s16 < zero_reg;
    assign lo        = lower ? span_low_reg : zero_reg;
    assign hi        = lower ? zero_reg : span_high_reg;
    assign diff      = s16 - lo;
    assign tgt_span  = lower ? LO_RANGE : HI_RANGE;

    // tolerance = trunc(width * 15 / 100) = sign * floor(floor(|width| * 3 / 4) / 5)
    assign width17 = {1'b0, dead_high_reg} - {1'b0, dead_low_reg};
    assign mag17   = width17[16] ? (17'd0 - width17) : width17;
    assign mag3    = 18'(mag17[15:0]) * 18'd3;
    assign y       = mag3[17:2];

    assign q_est    = tprod_reg[29:16];
    assign rmd      = y_reg - ({2'b00, q_est} + {q_est, 2'b00});
    assign tol_mag  = {1'b0, q_est} + 15'(rmd >= 16'd5);
    assign tol_s    = neg_reg ? -$signed(19'(tol_mag)) : $signed(19'(tol_mag));
    assign lo_bound = $signed({3'b000, dead_low_reg}) - tol_s;
    assign hi_bound = $signed({3'b000, dead_high_reg}) + tol_s;
    assign sv       = $signed(19'(sample_reg));

    assign trial = {rem_reg, num_reg[DIV_W-1]};
    assign qbit  = trial >= {1'b0, dvsr_reg};

    assign rail = (sample_reg > RAIL_LOW) && (sample_reg < RAIL_HIGH);

    always_comb
    begin
        span_low_next  = span_low_reg;
        span_high_next = span_high_reg;
        dead_low_next  = dead_low_reg;
        dead_high_next = dead_high_reg;
        if (cfg_we)
        begin
            case (cfg_sel)
                REG_DEAD_MAX: dead_high_next = cfg_data;
                REG_DEAD_MIN: dead_low_next  = cfg_data;
                REG_SPAN_MAX: span_high_next = cfg_data;
                REG_SPAN_MIN: span_low_next  = cfg_data;
                default:      span_low_next  = cfg_data;
            endcase
        end
        else if (ctl.commit)
        begin
            if (ctl.learn && rail)
            begin
                if (ctl.learn_dead)
                begin
                    if (s16 < dead_low_reg)
                        dead_low_next = s16;
                    if (s16 > dead_high_reg)
                        dead_high_next = s16;
                end
                else
                begin
                    if (s16 < span_low_reg)
                        span_low_next = s16;
                    if (s16 > span_high_reg)
                        span_high_next = s16;
                end
            end
            if (ctl.clear)
            begin
                span_low_next  = CLEARED_LOW;
                span_high_next = CLEARED_HIGH;
                dead_low_next  = CLEARED_LOW;
                dead_high_next = CLEARED_HIGH;
            end
        end
        dead_sum  = {1'b0, dead_low_next} + {1'b0, dead_high_next};
        zero_next = zero_reg;
        if (cfg_we || (ctl.commit && ctl.learn && ctl.learn_dead))
            zero_next = dead_sum[16:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_low_reg  <= RST_SPAN_MIN;
            span_high_reg <= RST_SPAN_MAX;
            dead_low_reg  <= RST_DEAD_MIN;
            dead_high_reg <= RST_DEAD_MAX;
            zero_reg      <= RST_ZERO;
        end
        else
        begin
            span_low_reg  <= span_low_next;
            span_high_reg <= span_high_next;
            dead_low_reg  <= dead_low_next;
            dead_high_reg <= dead_high_next;
            zero_reg      <= zero_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
            sample_reg <= sample;
        if (ctl.mul)
        begin
            lower_reg  <= lower;
            sat_lo_reg <= s16 <= lo;
            sat_hi_reg <= s16 >= hi;
            dvsr_reg   <= hi - lo;
            // offset is below 2^10 whenever the result is used
            prod_reg   <= DIV_W'(32'(diff[SAMPLE_W-1:0]) * tgt_span);
            y_reg      <= y;
            neg_reg    <= width17[16];
            tprod_reg  <= 30'(y * RECIP_5);
        end
        if (ctl.add)
        begin
            num_reg     <= prod_reg + DIV_W'(dvsr_reg >> 1);
            rem_reg     <= '0;
            in_dead_reg <= (sv >= lo_bound) && (sv <= hi_bound);
        end
        if (ctl.div)
        begin
            rem_reg <= qbit ? 16'(trial - {1'b0, dvsr_reg}) : trial[15:0];
            num_reg <= {num_reg[DIV_W-2:0], qbit};
        end
    end

    always_comb
    begin
        res.in_dead = in_dead_reg;
        res.in_rail = rail;
        if (sat_lo_reg)
            res.mapped = lower_reg ? MIN_B : MID_B;
        else if (sat_hi_reg)
            res.mapped = lower_reg ? MID_B : MAX_B;
        else
            res.mapped = (lower_reg ? MIN_B : MID_B) + num_reg[REPORT_W-1:0];
    end

endmodule

// ----- rtl/jacm_ctrl.sv -----
module jacm_ctrl import jacm_pkg::*;
#(
    parameter int LOGICAL_MIN = DEF_LOGICAL_MIN,
    parameter int LOGICAL_MAX = DEF_LOGICAL_MAX,
    parameter int HOLD_TICKS  = DEF_HOLD_TICKS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                button_one,
    input  logic                button_two,
    output lane_ctl_t           ctl,
    input  lane_res_t           res_a,
    input  lane_res_t           res_b,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [REPORT_W-1:0] report_axis_a,
    output logic [REPORT_W-1:0] report_axis_b,
    output logic [1:0]          button_bits,
    output logic                calibrating,
    output logic                save_pulse
);

    localparam logic [31:0]         MID_W     = logical_mid(LOGICAL_MIN, LOGICAL_MAX);
    localparam logic [REPORT_W-1:0] MID_B     = MID_W[REPORT_W-1:0];
    localparam logic [CNT_W-1:0]    DIV_LAST  = CNT_W'(DIV_W - 1);

    ctrl_state_t         state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic                b1_reg;
    logic                b2_reg;
    logic [HOLD_W-1:0]   hold_reg, hold_next;
    logic                calib_reg, calib_next;
    logic                fire;
    logic                out_free;
    logic                both_in;

    logic                out_valid_reg;
    logic [REPORT_W-1:0] rep_a_reg;
    logic [REPORT_W-1:0] rep_b_reg;
    logic [1:0]          bits_reg;
    logic                calib_out_reg;
    logic                save_reg;

    assign fire     = b1_reg && b2_reg && (32'(hold_reg) > 32'(HOLD_TICKS));
    assign out_free = !out_valid_reg || out_ready;
    assign both_in  = res_a.in_dead && res_b.in_dead;

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        ctl            = '0;
        ctl.learn      = calib_reg;
        ctl.learn_dead = b1_reg;
        ctl.clear      = fire && !calib_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.start  = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                ctl.mul    = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                ctl.add    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                ctl.div = 1'b1;
                if (cnt_reg == DIV_LAST)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    ctl.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        if (b1_reg && b2_reg)
            hold_next = fire ? '0 : hold_reg + 1'b1;
        else
            hold_next = '0;
        calib_next = fire ? !calib_reg : calib_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hold_reg      <= '0;
            calib_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctl.commit)
            begin
                hold_reg      <= hold_next;
                calib_reg     <= calib_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            b1_reg <= button_one;
            b2_reg <= button_two;
        end
        if (ctl.add)
            cnt_reg <= '0;
        else if (ctl.div)
            cnt_reg <= cnt_reg + 1'b1;
        if (ctl.commit)
        begin
            rep_a_reg     <= (res_a.in_rail && !both_in) ? res_a.mapped : MID_B;
            rep_b_reg     <= (res_b.in_rail && !both_in) ? res_b.mapped : MID_B;
            bits_reg      <= {b2_reg, b1_reg};
            calib_out_reg <= calib_next;
            save_reg      <= fire && calib_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign report_axis_a = rep_a_reg;
    assign report_axis_b = rep_b_reg;
    assign button_bits   = bits_reg;
    assign calibrating   = calib_out_reg;
    assign save_pulse    = save_reg;

endmodule

// ----- rtl/joystick_axis_calibrate_map.sv -----
// Joystick axis calibration and mapping. One item carries both stick samples and
// two buttons; one report item comes back for each. The two axes run in twin lanes
// that each own their extents and zero point; a control stage merges the deadzone
// decision, runs the button hold counter and the calibration mode. Items are taken
// one at a time, and each passes the 32-step restoring divider in each lane before
// its report is registered. The report register lets the next item enter while the
// last report waits. Configuration writes (cfg_idx 0..7) load the extents at once
// and are meant for idle time; an index of 8 or more is ignored.
module joystick_axis_calibrate_map import jacm_pkg::*;
#(
    parameter int LOGICAL_MIN = DEF_LOGICAL_MIN,
    parameter int LOGICAL_MAX = DEF_LOGICAL_MAX,
    parameter int HOLD_TICKS  = DEF_HOLD_TICKS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    jacm_in_if.sink               stick,
    jacm_out_if.source            report,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [EXTENT_W-1:0]   cfg_data
);

    lane_ctl_t ctl;
    lane_res_t res_a;
    lane_res_t res_b;
    logic      cfg_we_a;
    logic      cfg_we_b;

    assign cfg_we_a = cfg_we && !cfg_idx[3] && !cfg_idx[2];
    assign cfg_we_b = cfg_we && !cfg_idx[3] &&  cfg_idx[2];

    jacm_lane #(
        .LOGICAL_MIN (LOGICAL_MIN),
        .LOGICAL_MAX (LOGICAL_MAX)
    ) u_lane_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .sample   (stick.sample_axis_a),
        .cfg_we   (cfg_we_a),
        .cfg_sel  (cfg_idx[1:0]),
        .cfg_data (cfg_data),
        .res      (res_a)
    );

    jacm_lane #(
        .LOGICAL_MIN (LOGICAL_MIN),
        .LOGICAL_MAX (LOGICAL_MAX)
    ) u_lane_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .sample   (stick.sample_axis_b),
        .cfg_we   (cfg_we_b),
        .cfg_sel  (cfg_idx[1:0]),
        .cfg_data (cfg_data),
        .res      (res_b)
    );

    jacm_ctrl #(
        .LOGICAL_MIN (LOGICAL_MIN),
        .LOGICAL_MAX (LOGICAL_MAX),
        .HOLD_TICKS  (HOLD_TICKS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (stick.valid),
        .in_ready      (stick.ready),
        .button_one    (stick.button_one),
        .button_two    (stick.button_two),
        .ctl           (ctl),
        .res_a         (res_a),
        .res_b         (res_b),
        .out_valid     (report.valid),
        .out_ready     (report.ready),
        .report_axis_a (report.report_axis_a),
        .report_axis_b (report.report_axis_b),
        .button_bits   (report.button_bits),
        .calibrating   (report.calibrating),
        .save_pulse    (report.save_pulse)
    );

endmodule

// ----- rtl/jacm_checker.sv -----
module jacm_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic calibrating,
    input logic save_pulse
);

    // one item at a time: taking an item closes the input
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in flight");

    // a report never appears right after the item was taken
    a_no_instant_report: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
        else $error("report too early after input");

    // the save item is the one that leaves calibration
    a_save_ends_cal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && save_pulse |-> !calibrating)
        else $error("save pulse while still calibrating");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("report dropped while stalled");

endmodule

bind joystick_axis_calibrate_map jacm_checker u_jacm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (stick.valid),
    .in_ready    (stick.ready),
    .out_valid   (report.valid),
    .out_ready   (report.ready),
    .calibrating (report.calibrating),
    .save_pulse  (report.save_pulse)
);

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench import jacm_pkg::*;;

    localparam int unsigned REP_MID = (DEF_LOGICAL_MAX + DEF_LOGICAL_MIN) / 2;
    localparam logic [REPORT_W-1:0] MID8 = REPORT_W'(REP_MID);
    localparam logic [REPORT_W-1:0] LOW8 = REPORT_W'(DEF_LOGICAL_MIN);
    localparam logic [REPORT_W-1:0] HIGH8 = REPORT_W'(DEF_LOGICAL_MAX);

    // deadzone widening of 15 percent
    localparam int WIDEN_NUM = 15;
    localparam int WIDEN_DEN = 100;

    localparam int SQUEEZE_CYCLES = 400;
    localparam int DRAIN_CYCLES = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_MAX_A = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_MIN_A = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_MAX_A = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_MIN_A = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_MAX_B = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_MIN_B = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_MAX_B = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_MIN_B = 4'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 4'd8;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 4'd15;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sa;
        logic [SAMPLE_W-1:0] sb;
        logic                b1;
        logic                b2;
    } stick_t;

    typedef struct packed {
        logic [REPORT_W-1:0] ra;
        logic [REPORT_W-1:0] rb;
        logic [1:0]          bits;
        logic                cal;
        logic                save;
    } rep_t;

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [EXTENT_W-1:0]   data;
        stick_t                stim;
        logic                  typed;
        rep_t                  want;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [EXTENT_W-1:0]  cfg_data;

    jacm_in_if  stick_if ();
    jacm_out_if report_if ();

    joystick_axis_calibrate_map uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .stick    (stick_if),
        .report   (report_if),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    // predicted block state
    logic                cal_on;
    logic [HOLD_W-1:0]   hold_cnt;
    logic [EXTENT_W-1:0] span_lo [2];
    logic [EXTENT_W-1:0] span_hi [2];
    logic [EXTENT_W-1:0] dz_lo [2];
    logic [EXTENT_W-1:0] dz_hi [2];
    logic [EXTENT_W-1:0] centre [2];

    rep_t     pending_reports [$];
    dir_row_t dir_rows [$];

    int errors;
    int items_sent;
    int reports_seen;
    int reg_writes;
    int cal_entries;
    int saves_seen;
    bit idle_on;
    bit squeeze_req;

    task automatic flag(input string msg);
        errors++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            flag($sformatf("report %0d %s: got %0d want %0d", reports_seen, name, got, want));
    endtask

    function automatic logic [EXTENT_W-1:0] dead_mid(input logic [EXTENT_W-1:0] lo,
                                                     input logic [EXTENT_W-1:0] hi);
        logic [EXTENT_W:0] sum;
        sum = {1'b0, lo} + {1'b0, hi};
        return sum[EXTENT_W:1];
    endfunction

    function automatic logic [REPORT_W-1:0] scale8(input int unsigned v, input int unsigned lo,
                                                   input int unsigned hi, input int unsigned tlo,
                                                   input int unsigned thi);
        int unsigned in_span;
        int unsigned out_span;
        int unsigned mapped;
        if (v <= lo)
            return REPORT_W'(tlo);
        if (v >= hi)
            return REPORT_W'(thi);
        in_span = hi - lo;
        out_span = thi - tlo;
        mapped = ((v - lo) * out_span + in_span / 2) / in_span;
        return REPORT_W'(tlo + mapped);
    endfunction

    function automatic bit on_travel(input logic [SAMPLE_W-1:0] s);
        return s > RAIL_LOW && s < RAIL_HIGH;
    endfunction

    function automatic void load_extents();
        cal_on = 1'b0;
        hold_cnt = '0;
        for (int ax = 0; ax < 2; ax++)
        begin
            dz_hi[ax] = RST_DEAD_MAX;
            dz_lo[ax] = RST_DEAD_MIN;
            span_hi[ax] = RST_SPAN_MAX;
            span_lo[ax] = RST_SPAN_MIN;
            centre[ax] = dead_mid(RST_DEAD_MIN, RST_DEAD_MAX);
        end
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [EXTENT_W-1:0] v);
        int ax;
        if (idx > CFG_SPAN_MIN_B)
            return;
        ax = int'(idx[2]);
        case (idx[1:0])
            REG_DEAD_MAX: dz_hi[ax] = v;
            REG_DEAD_MIN: dz_lo[ax] = v;
            REG_SPAN_MAX: span_hi[ax] = v;
            default:      span_lo[ax] = v;
        endcase
        centre[ax] = dead_mid(dz_lo[ax], dz_hi[ax]);
    endfunction

    // report for one tick, then advance calibration and hold state
    function automatic rep_t map_tick(input stick_t it);
        rep_t                r;
        logic [SAMPLE_W-1:0] s [2];
        logic [REPORT_W-1:0] lane [2];
        bit                  all_dead;
        int                  w;
        int                  tol;
        int                  sv;
        int                  lo_i;
        int                  hi_i;
        logic [HOLD_W-1:0]   old;
        r = '0;
        s[0] = it.sa;
        s[1] = it.sb;
        all_dead = 1'b1;
        for (int ax = 0; ax < 2; ax++)
        begin
            lo_i = int'(dz_lo[ax]);
            hi_i = int'(dz_hi[ax]);
            w = hi_i - lo_i;
            tol = (w * WIDEN_NUM) / WIDEN_DEN;
            sv = int'(s[ax]);
            if (sv < lo_i - tol || sv > hi_i + tol)
                all_dead = 1'b0;
        end
        for (int ax = 0; ax < 2; ax++)
        begin
            if (on_travel(s[ax]) && !all_dead)
            begin
                if (s[ax] < centre[ax])
                    lane[ax] = scale8(s[ax], span_lo[ax], centre[ax], DEF_LOGICAL_MIN, REP_MID);
                else
                    lane[ax] = scale8(s[ax], centre[ax], span_hi[ax], REP_MID, DEF_LOGICAL_MAX);
            end
            else
                lane[ax] = MID8;
        end

        if (cal_on)
        begin
            for (int ax = 0; ax < 2; ax++)
            begin
                if (on_travel(s[ax]))
                begin
                    if (it.b1)
                    begin
                        if (s[ax] < dz_lo[ax]) dz_lo[ax] = EXTENT_W'(s[ax]);
                        if (s[ax] > dz_hi[ax]) dz_hi[ax] = EXTENT_W'(s[ax]);
                    end
                    else
                    begin
                        if (s[ax] < span_lo[ax]) span_lo[ax] = EXTENT_W'(s[ax]);
                        if (s[ax] > span_hi[ax]) span_hi[ax] = EXTENT_W'(s[ax]);
                    end
                end
            end
            if (it.b1)
                for (int ax = 0; ax < 2; ax++)
                    centre[ax] = dead_mid(dz_lo[ax], dz_hi[ax]);
        end

        if (it.b1 && it.b2)
        begin
            old = hold_cnt;
            hold_cnt = old + 1'b1;
            if (old > DEF_HOLD_TICKS)
            begin
                hold_cnt = '0;
                if (cal_on)
                begin
                    cal_on = 1'b0;
                    r.save = 1'b1;
                    saves_seen++;
                    for (int ax = 0; ax < 2; ax++)
                        centre[ax] = dead_mid(dz_lo[ax], dz_hi[ax]);
                end
                else
                begin
                    cal_on = 1'b1;
                    cal_entries++;
                    for (int ax = 0; ax < 2; ax++)
                    begin
                        span_lo[ax] = CLEARED_LOW;
                        span_hi[ax] = CLEARED_HIGH;
                        dz_lo[ax] = CLEARED_LOW;
                        dz_hi[ax] = CLEARED_HIGH;
                    end
                end
            end
        end
        else
            hold_cnt = '0;

        r.ra = lane[0];
        r.rb = lane[1];
        r.bits = {it.b2, it.b1};
        r.cal = cal_on;
        return r;
    endfunction

    function automatic dir_row_t row_plain(input int a, input int b, input bit b1, input bit b2);
        dir_row_t row;
        row = '0;
        row.kind = ROW_ITEM;
        row.stim = '{sa: SAMPLE_W'(a), sb: SAMPLE_W'(b), b1: b1, b2: b2};
        return row;
    endfunction

    function automatic dir_row_t row_known(input int a, input int b, input bit b1, input bit b2,
                                           input logic [REPORT_W-1:0] ra,
                                           input logic [REPORT_W-1:0] rb);
        dir_row_t row;
        row = row_plain(a, b, b1, b2);
        row.typed = 1'b1;
        row.want = '{ra: ra, rb: rb, bits: {b2, b1}, cal: 1'b0, save: 1'b0};
        return row;
    endfunction

    function automatic dir_row_t row_reg(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [EXTENT_W-1:0] data);
        dir_row_t row;
        row = '0;
        row.kind = ROW_REG;
        row.idx = idx;
        row.data = data;
        return row;
    endfunction

    // entered at a falling edge with valid untouched in this step
    task automatic send_item(input stick_t it, input bit typed, input rep_t typed_want);
        rep_t want;
        while (idle_on && $urandom_range(99) < 26)
        begin
            stick_if.valid <= 1'b0;
            @(negedge clk);
        end
        stick_if.valid <= 1'b1;
        stick_if.sample_axis_a <= it.sa;
        stick_if.sample_axis_b <= it.sb;
        stick_if.button_one <= it.b1;
        stick_if.button_two <= it.b2;
        @(posedge clk);
        while (!stick_if.ready)
            @(posedge clk);
        want = map_tick(it);
        pending_reports.push_back(typed ? typed_want : want);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        stick_if.valid <= 1'b0;
        @(negedge clk);
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [EXTENT_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        apply_reg(idx, data);
        reg_writes++;
    endtask

    task automatic restore_defaults();
        for (int ax = 0; ax < 2; ax++)
        begin
            cfg_write({1'b0, 1'(ax), REG_DEAD_MAX}, RST_DEAD_MAX);
            cfg_write({1'b0, 1'(ax), REG_DEAD_MIN}, RST_DEAD_MIN);
            cfg_write({1'b0, 1'(ax), REG_SPAN_MAX}, RST_SPAN_MAX);
            cfg_write({1'b0, 1'(ax), REG_SPAN_MIN}, RST_SPAN_MIN);
        end
    endtask

    // plausible extents; wild mode throws in arbitrary 16-bit values
    task automatic set_extents(input bit wild);
        int c;
        int hw;
        for (int ax = 0; ax < 2; ax++)
        begin
            c = $urandom_range(624, 400);
            hw = $urandom_range(40);
            cfg_write({1'b0, 1'(ax), REG_DEAD_MAX}, EXTENT_W'(c + hw));
            cfg_write({1'b0, 1'(ax), REG_DEAD_MIN}, EXTENT_W'(c - hw));
            cfg_write({1'b0, 1'(ax), REG_SPAN_MAX}, EXTENT_W'($urandom_range(1023, 960)));
            cfg_write({1'b0, 1'(ax), REG_SPAN_MIN}, EXTENT_W'($urandom_range(60)));
            if (wild)
                cfg_write({1'b0, 1'(ax), 2'($urandom_range(3))}, EXTENT_W'($urandom));
        end
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(input int ax);
        int v;
        case ($urandom_range(9))
            0: v = $urandom_range(12);
            1: v = $urandom_range(1023, 1010);
            2, 3:
            begin
                v = int'(centre[ax]) + int'($urandom_range(60)) - 30;
                if (v < 0) v = 0;
                if (v > 1023) v = 1023;
            end
            default: v = $urandom_range(1023);
        endcase
        return SAMPLE_W'(v);
    endfunction

    function automatic stick_t noise_item();
        stick_t it;
        int roll;
        it.sa = pick_sample(0);
        it.sb = pick_sample(1);
        roll = $urandom_range(99);
        it.b1 = (roll >= 40 && roll < 60) || roll >= 75;
        it.b2 = roll >= 60;
        return it;
    endfunction

    task automatic send_noise(input int n);
        stick_t it;
        for (int i = 0; i < n; i++)
        begin
            // now and then a hold that is let go early
            if ($urandom_range(99) < 1)
            begin
                repeat ($urandom_range(60, 1))
                begin
                    it = noise_item();
                    it.b1 = 1'b1;
                    it.b2 = 1'b1;
                    send_item(it, 1'b0, '0);
                end
            end
            it = noise_item();
            send_item(it, 1'b0, '0);
        end
    endtask

    // both buttons down until calibration mode flips
    task automatic long_hold();
        stick_t it;
        bit start_mode;
        int guard;
        start_mode = cal_on;
        guard = 0;
        while (cal_on == start_mode && guard < 2 * DEF_HOLD_TICKS)
        begin
            it = noise_item();
            it.b1 = 1'b1;
            it.b2 = 1'b1;
            send_item(it, 1'b0, '0);
            guard++;
        end
    endtask

    task automatic learn_extents(input int n);
        stick_t it;
        int roll;
        for (int i = 0; i < n; i++)
        begin
            it = noise_item();
            roll = $urandom_range(99);
            if (roll < 70)
            begin
                it.b1 = 1'b0;
                it.sa = SAMPLE_W'($urandom_range(1023));
                it.sb = SAMPLE_W'($urandom_range(1023));
            end
            else if (roll < 90)
            begin
                it.b1 = 1'b1;
                it.b2 = 1'b0;
                it.sa = SAMPLE_W'($urandom_range(600, 420));
                it.sb = SAMPLE_W'($urandom_range(600, 420));
            end
            send_item(it, 1'b0, '0);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("** joystick_axis_calibrate_map: FAILED **");
        $finish;
    end

    // receiver side: random back-pressure plus one long hold-off on request
    initial
    begin
        report_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (squeeze_req)
            begin
                report_if.ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(negedge clk);
                squeeze_req = 1'b0;
                report_if.ready <= 1'b1;
            end
            else
                report_if.ready <= !(idle_on && $urandom_range(99) < 26);
        end
    end

    initial
    begin
        rep_t want;
        rep_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && report_if.valid && report_if.ready)
            begin
                got.ra = report_if.report_axis_a;
                got.rb = report_if.report_axis_b;
                got.bits = report_if.button_bits;
                got.cal = report_if.calibrating;
                got.save = report_if.save_pulse;
                reports_seen++;
                if (pending_reports.size() == 0)
                    flag($sformatf("report %0d arrived with no item pending", reports_seen));
                else
                begin
                    want = pending_reports.pop_front();
                    check_field("report_axis_a", got.ra, want.ra);
                    check_field("report_axis_b", got.rb, want.rb);
                    check_field("button_bits", 8'(got.bits), 8'(want.bits));
                    check_field("calibrating", 8'(got.cal), 8'(want.cal));
                    check_field("save_pulse", 8'(got.save), 8'(want.save));
                end
            end
        end
    end

    initial
    begin
        errors = 0;
        items_sent = 0;
        reports_seen = 0;
        reg_writes = 0;
        cal_entries = 0;
        saves_seen = 0;
        idle_on = 1'b1;
        squeeze_req = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        stick_if.valid = 1'b0;
        stick_if.sample_axis_a = '0;
        stick_if.sample_axis_b = '0;
        stick_if.button_one = 1'b0;
        stick_if.button_two = 1'b0;
        load_extents();

        dir_rows = {
            row_known(512, 512, 0, 0, MID8, MID8),
            row_known(0, 0, 0, 0, MID8, MID8),
            row_known(1023, 1023, 1, 0, MID8, MID8),
            row_known(10, 1013, 0, 1, MID8, MID8),
            row_known(11, 1012, 1, 1, LOW8, HIGH8),
            row_known(1012, 11, 0, 0, HIGH8, LOW8),
            row_known(497, 527, 0, 0, MID8, MID8),
            row_plain(496, 512, 0, 0),
            row_plain(512, 528, 0, 0),
            row_plain(682, 341, 1, 0),
            row_plain(341, 682, 0, 1),
            row_plain(600, 300, 1, 1),
            // inverted deadzone on axis a: negative width narrows the window
            row_reg(CFG_DEAD_MIN_A, 16'hFFFF),
            row_reg(CFG_DEAD_MAX_A, 16'h0000),
            row_reg(CFG_SPAN_MIN_A, 16'h0000),
            row_reg(CFG_SPAN_MAX_A, 16'hFFFF),
            row_plain(1012, 512, 0, 0),
            row_plain(100, 900, 0, 0),
            row_reg(CFG_DEAD_MAX_B, 16'hFFFF),
            row_reg(CFG_DEAD_MIN_B, 16'h0000),
            row_reg(CFG_SPAN_MAX_B, 16'h0000),
            row_reg(CFG_SPAN_MIN_B, 16'hFFFF),
            row_plain(512, 200, 0, 0),
            row_plain(11, 1012, 0, 0),
            // out-of-range indexes are ignored
            row_reg(CFG_UNUSED_LO, 16'h1234),
            row_reg(CFG_UNUSED_HI, 16'hFFFF),
            row_plain(700, 700, 0, 0)
        };

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_REG)
            begin
                drain();
                cfg_write(dir_rows[i].idx, dir_rows[i].data);
            end
            else
                send_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
        end

        drain();
        set_extents(1'b0);
        idle_on = 1'b0;
        send_noise(120);
        idle_on = 1'b1;
        squeeze_req = 1'b1;
        send_noise(80);

        drain();
        set_extents(1'b1);
        send_noise(80);
        drain();
        send_noise(40);

        // calibration session from the default extents
        drain();
        restore_defaults();
        long_hold();
        learn_extents(150);
        send_noise(50);
        drain();

        $display("Run covered %0d stick items and %0d reports over %0d register writes,",
                 items_sent, reports_seen, reg_writes);
        $display("with %0d calibration entries, %0d saves and a %0d-cycle receiver hold-off.",
                 cal_entries, saves_seen, SQUEEZE_CYCLES);
        if (errors == 0)
            $display("** joystick_axis_calibrate_map: PASSED **");
        else
            $display("** joystick_axis_calibrate_map: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/jacm_pkg.sv
rtl/jacm_in_if.sv
rtl/jacm_out_if.sv
rtl/jacm_lane.sv
rtl/jacm_ctrl.sv
rtl/joystick_axis_calibrate_map.sv
rtl/jacm_checker.sv
dv/testbench.sv
